>>> hdl/bfla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block free-list allocator package
// Field widths, command and status codes, and controller types shared by the
// allocator modules.
// ----------------------------------------------------------------------------
package bfla_pkg;

    localparam int ACTION_W       = 2;
    localparam int COUNT_W        = 7;
    localparam int ID_W           = 10;
    localparam int STATUS_W       = 2;
    localparam int CFG_W          = 11;
    localparam int CFG_RESET      = 1024;
    localparam int MAX_BATCH      = 64;
    localparam int DEF_MAX_BLOCKS = 1024;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE  = 2'd3;

    typedef enum logic [1:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_FREE,
        FSM_ALLOC
    } state_t;

    typedef struct packed {
        logic stack_we;
        logic bits_we;
    } mem_wen_t;

endpackage : bfla_pkg
`default_nettype wire

>>> hdl/bfla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : bfla_ram
`default_nettype wire

>>> hdl/bfla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block free-list allocator controller
// Sequencer that checks commands, walks the free stack and the allocated-bit
// memory, runs the refill pass and registers the results.
// ----------------------------------------------------------------------------
module bfla_ctrl
    import bfla_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ACTION_W-1:0]           action,
    input  wire logic [COUNT_W-1:0]            count,
    input  wire logic [ID_W-1:0]               free_id,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_W-1:0]              cfg_wdata,
    output logic                               busy,
    output logic                               result_valid,
    output logic [STATUS_W-1:0]                status,
    output logic [ID_W-1:0]                    granted_block,
    output logic                               last,
    output mem_wen_t                           wen,
    output logic [$clog2(MAX_BLOCKS)-1:0]      stack_waddr,
    output logic [ID_W-1:0]                    stack_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]      stack_raddr,
    input  wire logic [ID_W-1:0]               stack_rdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]      bits_waddr,
    output logic                               bits_wdata,
    output logic [$clog2(MAX_BLOCKS)-1:0]      bits_raddr,
    input  wire logic                          bits_rdata
);

    localparam int AW      = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int RESET_N = (CFG_RESET > MAX_BLOCKS) ? MAX_BLOCKS : CFG_RESET;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   active_reg;
    logic [CNT_W-1:0]   fc_reg, fc_next;
    logic [CNT_W-1:0]   managed_reg, managed_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [AW-1:0]      ptr_reg, ptr_next;

    logic                rv_reg, rv_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     gb_reg, gb_next;
    logic                last_reg, last_next;

    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] clamped_n;

    // An out-of-range block count is pulled into 1..MAX_BLOCKS.
    always_comb
    begin
        cfg_ext = CMP_W'(active_reg);
        if (cfg_ext == '0)
        begin
            clamped_n = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_BLOCKS))
        begin
            clamped_n = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            clamped_n = CNT_W'(active_reg);
        end
    end

    assign stack_raddr = AW'(fc_reg - CNT_W'(1));
    assign bits_raddr  = AW'(free_id);

    always_comb
    begin
        state_next   = state_reg;
        fc_next      = fc_reg;
        managed_next = managed_reg;
        left_next    = left_reg;
        id_next      = id_reg;
        ptr_next     = ptr_reg;
        rv_next      = 1'b0;
        status_next  = STATUS_OK;
        gb_next      = '0;
        last_next    = 1'b1;
        wen          = '0;
        stack_waddr  = AW'(fc_reg);
        stack_wdata  = id_reg;
        bits_waddr   = AW'(id_reg);
        bits_wdata   = 1'b0;

        case (state_reg)
            FSM_INIT:
            begin
                wen.stack_we = 1'b1;
                wen.bits_we  = 1'b1;
                stack_waddr  = ptr_reg;
                stack_wdata  = ID_W'(ptr_reg);
                bits_waddr   = ptr_reg;
                if (ptr_reg == AW'(MAX_BLOCKS - 1))
                begin
                    ptr_next   = '0;
                    state_next = FSM_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            FSM_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (count == '0 || count > COUNT_W'(MAX_BATCH))
                            begin
                                rv_next     = 1'b1;
                                status_next = STATUS_INVALID;
                            end
                            else if (CMP_W'(fc_reg) < CMP_W'(count))
                            begin
                                rv_next     = 1'b1;
                                status_next = STATUS_OOM;
                            end
                            else
                            begin
                                // The first stack read goes out with the accept.
                                fc_next    = fc_reg - CNT_W'(1);
                                left_next  = count - COUNT_W'(1);
                                state_next = FSM_ALLOC;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (CMP_W'(free_id) >= CMP_W'(managed_reg))
                            begin
                                rv_next     = 1'b1;
                                status_next = STATUS_INVALID;
                            end
                            else
                            begin
                                id_next    = free_id;
                                state_next = FSM_FREE;
                            end
                        end
                        ACT_RESET:
                        begin
                            managed_next = clamped_n;
                            fc_next      = clamped_n;
                            ptr_next     = '0;
                            rv_next      = 1'b1;
                            state_next   = FSM_INIT;
                        end
                        default:
                        begin
                            rv_next     = 1'b1;
                            status_next = STATUS_INVALID;
                        end
                    endcase
                end
            end
            FSM_FREE:
            begin
                rv_next    = 1'b1;
                state_next = FSM_IDLE;
                if (!bits_rdata)
                begin
                    status_next = STATUS_DOUBLE;
                end
                else
                begin
                    wen.bits_we = 1'b1;
                    if (fc_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        wen.stack_we = 1'b1;
                        fc_next      = fc_reg + CNT_W'(1);
                    end
                end
            end
            FSM_ALLOC:
            begin
                // The block read in the previous cycle is granted now.
                wen.bits_we = 1'b1;
                bits_waddr  = AW'(stack_rdata);
                bits_wdata  = 1'b1;
                rv_next     = 1'b1;
                gb_next     = stack_rdata;
                last_next   = (left_reg == '0);
                if (left_reg != '0)
                begin
                    fc_next   = fc_reg - CNT_W'(1);
                    left_next = left_reg - COUNT_W'(1);
                end
                else
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_INIT;
            active_reg  <= CFG_W'(CFG_RESET);
            fc_reg      <= CNT_W'(RESET_N);
            managed_reg <= CNT_W'(RESET_N);
            left_reg    <= '0;
            ptr_reg     <= '0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fc_reg      <= fc_next;
            managed_reg <= managed_next;
            left_reg    <= left_next;
            ptr_reg     <= ptr_next;
            rv_reg      <= rv_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        status_reg <= status_next;
        gb_reg     <= gb_next;
        last_reg   <= last_next;
    end

    assign busy          = (state_reg != FSM_IDLE);
    assign result_valid  = rv_reg;
    assign status        = status_reg;
    assign granted_block = gb_reg;
    assign last          = last_reg;

`ifndef SYNTH
    a_fc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= managed_reg)
        else $error("free count exceeds managed block count");

    a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_ALLOC) |-> (wen.bits_we && bits_wdata && rv_next))
        else $error("granted block not marked allocated");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && status_reg != STATUS_OK) |-> (last_reg && gb_reg == '0))
        else $error("error result is not a single final item");

    a_free_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_FREE && wen.stack_we) |=> (fc_reg == $past(fc_reg) + CNT_W'(1)))
        else $error("free push did not advance free count");
`endif

endmodule : bfla_ctrl
`default_nettype wire

>>> hdl/block_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block free-list allocator
// LIFO stack of free block numbers with an allocated bit per block; grants
// batches of blocks, takes single blocks back and refills on command.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each result shows for
// one cycle with result_valid, in the cycle after the controller decides it,
// and the receiver cannot hold it off. A free waits in FSM_FREE for the
// registered read of the allocated-bit memory. An allocate of n blocks gives
// one result per cycle, one free-stack read per block. A rejected command
// gives its result without leaving idle. A reset command posts its result as
// it enters the refill pass, which rewrites one free-stack entry and one
// allocated bit per cycle. The same pass runs after rst_n, with busy high.
// Writes to active_blocks are taken at any time and act at the next reset
// command.
module block_free_list_allocator
    import bfla_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [COUNT_W-1:0]  count,
    input  wire logic [ID_W-1:0]     free_id,
    input  wire logic                active_blocks_we,
    input  wire logic [CFG_W-1:0]    active_blocks,
    output logic                     result_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [ID_W-1:0]          granted_block,
    output logic                     last
);

    localparam int AW = $clog2(MAX_BLOCKS);

    mem_wen_t      wen;
    logic [AW-1:0] stack_waddr;
    logic [ID_W-1:0] stack_wdata;
    logic [AW-1:0] stack_raddr;
    logic [ID_W-1:0] stack_rdata;
    logic [AW-1:0] bits_waddr;
    logic          bits_wdata;
    logic [AW-1:0] bits_raddr;
    logic          bits_rdata;

    bfla_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .count         (count),
        .free_id       (free_id),
        .cfg_we        (active_blocks_we),
        .cfg_wdata     (active_blocks),
        .busy          (busy),
        .result_valid  (result_valid),
        .status        (status),
        .granted_block (granted_block),
        .last          (last),
        .wen           (wen),
        .stack_waddr   (stack_waddr),
        .stack_wdata   (stack_wdata),
        .stack_raddr   (stack_raddr),
        .stack_rdata   (stack_rdata),
        .bits_waddr    (bits_waddr),
        .bits_wdata    (bits_wdata),
        .bits_raddr    (bits_raddr),
        .bits_rdata    (bits_rdata)
    );

    bfla_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (wen.stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    bfla_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_bits_ram (
        .clk   (clk),
        .we    (wen.bits_we),
        .waddr (bits_waddr),
        .wdata (bits_wdata),
        .raddr (bits_raddr),
        .rdata (bits_rdata)
    );

endmodule : block_free_list_allocator
`default_nettype wire

>>> tb/sv/block_free_list_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free-list allocator checker
// Watches the command and result channels, keeps its own copy of the free
// stack, allocated bits and pool size, and compares every result in order.
// ----------------------------------------------------------------------------
module block_free_list_allocator_checker
    import bfla_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [ACTION_W-1:0] action,
    input  logic [COUNT_W-1:0]  count,
    input  logic [ID_W-1:0]     free_id,
    input  logic                active_blocks_we,
    input  logic [CFG_W-1:0]    active_blocks,
    input  logic                result_valid,
    input  logic [STATUS_W-1:0] status,
    input  logic [ID_W-1:0]     granted_block,
    input  logic                last,
    output int                  mismatches,
    output int                  outstanding,
    output int                  replies_checked
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     block;
        logic                last;
    } reply_t;

    logic [ID_W-1:0]  free_ids [MAX_BLOCKS];
    logic             held_bit [MAX_BLOCKS];
    int unsigned      free_depth;
    int unsigned      pool_size;
    logic [CFG_W-1:0] pool_cfg;
    reply_t           due_replies [$];

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic push_reply(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] blk,
                              input logic lst);
        reply_t r;
        r.status = st;
        r.block  = blk;
        r.last   = lst;
        due_replies = {due_replies, r};
    endtask

    // The register value is clamped into 1..MAX_BLOCKS when it is taken into use.
    task automatic refill_pool();
        int unsigned n;
        n = pool_cfg;
        if (n == 0)
            n = 1;
        if (n > MAX_BLOCKS)
            n = MAX_BLOCKS;
        pool_size = n;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            free_ids[i] = ID_W'(i);
            held_bit[i] = 1'b0;
        end
        free_depth = n;
    endtask

    task automatic apply_command(input logic [ACTION_W-1:0] act,
                                 input logic [COUNT_W-1:0] cnt,
                                 input logic [ID_W-1:0] id);
        logic [ID_W-1:0] blk;
        case (act)
            ACT_ALLOC:
            begin
                if (cnt == 0 || cnt > MAX_BATCH)
                    push_reply(STATUS_INVALID, '0, 1'b1);
                else if (free_depth < cnt)
                    push_reply(STATUS_OOM, '0, 1'b1);
                else
                begin
                    for (int k = 1; k <= cnt; k++)
                    begin
                        free_depth--;
                        blk = free_ids[free_depth];
                        held_bit[blk] = 1'b1;
                        push_reply(STATUS_OK, blk, k == cnt);
                    end
                end
            end
            ACT_FREE:
            begin
                if (id >= pool_size)
                    push_reply(STATUS_INVALID, '0, 1'b1);
                else if (!held_bit[id])
                    push_reply(STATUS_DOUBLE, '0, 1'b1);
                else
                begin
                    if (free_depth < MAX_BLOCKS)
                    begin
                        free_ids[free_depth] = id;
                        free_depth++;
                    end
                    held_bit[id] = 1'b0;
                    push_reply(STATUS_OK, '0, 1'b1);
                end
            end
            ACT_RESET:
            begin
                refill_pool();
                push_reply(STATUS_OK, '0, 1'b1);
            end
            default:
                push_reply(STATUS_INVALID, '0, 1'b1);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            pool_cfg = CFG_W'(CFG_RESET);
            refill_pool();
            due_replies.delete();
            mismatches      = 0;
            replies_checked = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (due_replies.size() == 0)
                    report($sformatf("result with nothing outstanding: status %0d block %0d",
                                     status, granted_block));
                else
                begin
                    want = due_replies.pop_front();
                    replies_checked++;
                    if (status !== want.status)
                        report($sformatf("status %0d, expected %0d", status, want.status));
                    if (granted_block !== want.block)
                        report($sformatf("granted_block %0d, expected %0d",
                                         granted_block, want.block));
                    if (last !== want.last)
                        report($sformatf("last %0b, expected %0b", last, want.last));
                end
            end
            if (active_blocks_we)
                pool_cfg = active_blocks;
            if (start && !busy)
                apply_command(action, count, free_id);
        end
        outstanding = due_replies.size();
    end

endmodule

>>> tb/sv/block_free_list_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free-list allocator testbench
// Directed allocate, free and reset commands at the field limits, then random
// phases at several pool sizes, most with sender gaps; results go to the checker.
// ----------------------------------------------------------------------------
module block_free_list_allocator_test;
    import bfla_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 40;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] action;
    logic [COUNT_W-1:0]  count;
    logic [ID_W-1:0]     free_id;
    logic                active_blocks_we;
    logic [CFG_W-1:0]    active_blocks;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     granted_block;
    logic                last;

    int mismatches;
    int outstanding;
    int replies_checked;
    int commands_sent;
    int sizes_tried;

    int pool_sizes [PHASES] = '{3, 16, 1024, 7, 64, 2047, 40, 1, 1024, 0, 300};

    // Blocks seen granted, so that most frees name a block that is really held.
    logic [ID_W-1:0] held_ids [$];

    block_free_list_allocator u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .count            (count),
        .free_id          (free_id),
        .active_blocks_we (active_blocks_we),
        .active_blocks    (active_blocks),
        .result_valid     (result_valid),
        .status           (status),
        .granted_block    (granted_block),
        .last             (last)
    );

    block_free_list_allocator_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .count            (count),
        .free_id          (free_id),
        .active_blocks_we (active_blocks_we),
        .active_blocks    (active_blocks),
        .result_valid     (result_valid),
        .status           (status),
        .granted_block    (granted_block),
        .last             (last),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .replies_checked  (replies_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && result_valid && status == STATUS_OK && granted_block != '0)
            held_ids = {held_ids, granted_block};

    task automatic send(input logic [ACTION_W-1:0] act, input int cnt, input int id);
        start   <= 1'b1;
        action  <= act;
        count   <= COUNT_W'(cnt);
        free_id <= ID_W'(id);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        commands_sent++;
        if (act == ACT_RESET)
            held_ids.delete();
    endtask

    // Drains every pending result and any refill pass so the block is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_pool_size(input int value);
        active_blocks_we <= 1'b1;
        active_blocks    <= CFG_W'(value);
        @(posedge clk);
        active_blocks_we <= 1'b0;
        sizes_tried++;
    endtask

    initial
    begin
        int  r;
        int  cnt;
        int  id;
        int  slot;
        int  span;
        int  gap;
        bit  greedy;
        bit  quiet;
        rst_n            = 1'b0;
        start            = 1'b0;
        action           = ACT_ALLOC;
        count            = '0;
        free_id          = '0;
        active_blocks_we = 1'b0;
        active_blocks    = CFG_W'(CFG_RESET);
        commands_sent    = 0;
        sizes_tried      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full pool: bad counts, single and full-batch grants, frees and
        // double frees, and the unused action code.
        send(ACT_ALLOC, 0, 1023);
        send(ACT_ALLOC, MAX_BATCH + 1, 0);
        send(ACT_ALLOC, 127, 511);
        send(ACT_ALLOC, 1, 0);
        send(ACT_ALLOC, MAX_BATCH, 0);
        send(ACT_FREE, 127, 1023);
        send(ACT_FREE, 0, 1023);
        send(ACT_FREE, 0, 0);
        send(ACT_UNUSED, 127, 1023);
        send(ACT_ALLOC, 1, 0);

        // A register write alone must not shrink the pool; the reset command
        // then takes zero as a pool of one block.
        settle();
        write_pool_size(0);
        send(ACT_FREE, 0, 512);
        send(ACT_RESET, 0, 0);
        send(ACT_ALLOC, 2, 0);
        send(ACT_ALLOC, 1, 0);
        send(ACT_FREE, 0, 1);
        send(ACT_FREE, 0, 1023);
        send(ACT_FREE, 0, 0);
        send(ACT_FREE, 0, 0);

        // An oversized register value is clamped to the whole pool.
        settle();
        write_pool_size(2047);
        send(ACT_RESET, 127, 1023);
        send(ACT_ALLOC, MAX_BATCH, 1023);
        send(ACT_FREE, 0, 960);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_pool_size(pool_sizes[p]);
            span   = (pool_sizes[p] == 0) ? 1 :
                     (pool_sizes[p] > 1024) ? 1024 : pool_sizes[p];
            greedy = (span >= 512) && ($urandom_range(0, 1) == 1);
            quiet  = (p % 3 == 1);
            send(ACT_RESET, $urandom_range(0, 127), $urandom_range(0, 1023));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                gap = 0;
                if (!quiet)
                begin
                    r = $urandom_range(0, 99);
                    if (r >= 95)
                        gap = $urandom_range(8, 40);
                    else if (r >= 60)
                        gap = $urandom_range(1, 3);
                end
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end

                r = $urandom_range(0, 99);
                if (r < (greedy ? 80 : 47))
                begin
                    r = $urandom_range(0, 99);
                    if (greedy)
                        cnt = $urandom_range(24, MAX_BATCH);
                    else if (r < 65)
                        cnt = $urandom_range(1, (span < 8) ? span + 1 : 8);
                    else if (r < 92)
                        cnt = $urandom_range(9, MAX_BATCH);
                    else
                        cnt = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_BATCH + 1, 127);
                    send(ACT_ALLOC, cnt, $urandom_range(0, 1023));
                end
                else if (r < 92)
                begin
                    r = $urandom_range(0, 99);
                    if (held_ids.size() > 0 && r < 70)
                    begin
                        slot = $urandom_range(0, held_ids.size() - 1);
                        id   = held_ids[slot];
                        held_ids.delete(slot);
                    end
                    else if (r < 85)
                        id = $urandom_range(0, (span + 2 > 1023) ? 1023 : span + 2);
                    else
                        id = $urandom_range(0, 1023);
                    send(ACT_FREE, $urandom_range(0, 127), id);
                end
                else if (r < 95)
                    send(ACT_RESET, $urandom_range(0, 127), $urandom_range(0, 1023));
                else if (r < 97)
                    send(ACT_UNUSED, $urandom_range(0, 127), $urandom_range(0, 1023));
                else
                    send(ACT_ALLOC, $urandom_range(0, 1) ? 0 : $urandom_range(MAX_BATCH + 1, 127),
                         $urandom_range(0, 1023));
            end
        end

        settle();
        repeat (50) @(posedge clk);
        $display("%0d commands over %0d pool size settings, %0d results checked, %0d mismatches",
                 commands_sent, sizes_tried, replies_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("status: fail");
        $finish;
    end

endmodule
